@@ sv/stb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg
// shared command codes and controller/datapath link types for the timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

    // command code carried by each input item
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ARM  = 2'd1,
        CMD_SCAN = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic scan_step;  // visit one channel of the scan walk
        logic load_out;   // capture the result into the output register
    } stb_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan pointer is on the last channel
    } stb_status_t;

endpackage
`default_nettype wire

@@ sv/stb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stb_ctrl
// sequencer for the timer bank: input handshake, scan walk, result handoff
// ----------------------------------------------------------------------------
module stb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          cmd,
    input  wire logic                out_stall,
    input  wire stb_pkg::stb_status_t status,
    output logic                     in_stall,
    output logic                     out_valid,
    output stb_pkg::stb_ctrl_t       ctrl
);
    import stb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        ctrl.accept    = 1'b0;
        ctrl.scan_step = 1'b0;
        ctrl.load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    if (cmd_t'(cmd) == CMD_SCAN)
                        state_next = S_SCAN;
                    else
                        state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctrl.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ sv/stb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stb_datapath
// time counter, expiry registers, event flags, scan pointer and output register
// ----------------------------------------------------------------------------
module stb_datapath #(
    parameter int CHANNELS  = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire stb_pkg::stb_ctrl_t  ctrl,
    input  wire logic [1:0]          cmd,
    input  wire logic [3:0]          timer_index,
    input  wire logic [31:0]         period,
    output stb_pkg::stb_status_t     status,
    output logic [31:0]              current_time,
    output logic [7:0]               event_bits,
    output logic                     selected_event,
    output logic                     rejected
);
    import stb_pkg::*;

    localparam int         CNT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    logic [TIME_BITS-1:0] expiry_reg [CHANNELS];
    logic [CHANNELS-1:0]  flags_reg;
    logic [CHANNELS-1:0]  flags_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [3:0]           idx_reg;
    logic                 rej_reg;
    logic [31:0]          out_time_reg;
    logic [7:0]           out_events_reg;
    logic                 out_sel_reg;
    logic                 out_rej_reg;

    logic                 in_range;
    logic                 arm_go;
    logic                 tick_go;
    logic                 scan_hit;
    logic [CNT_W-1:0]     arm_idx;
    logic                 exp_we;
    logic [CNT_W-1:0]     exp_addr;
    logic [TIME_BITS-1:0] exp_wdata;
    logic                 sel_bit;

    assign arm_idx  = timer_index[CNT_W-1:0];
    assign in_range = ({1'b0, timer_index} < CH_LIMIT);
    assign arm_go   = ctrl.accept && (cmd_t'(cmd) == CMD_ARM) && in_range;
    assign tick_go  = ctrl.accept && (cmd_t'(cmd) == CMD_TICK);
    // strict unsigned compare: an all-ones expiry never fires
    assign scan_hit = ctrl.scan_step && (time_reg > expiry_reg[cnt_reg]);

    assign status.scan_last = (cnt_reg == CNT_W'(CHANNELS - 1));

    always_comb
    begin
        time_next = tick_go ? time_reg + TIME_BITS'(1) : time_reg;

        flags_next = flags_reg;
        if (arm_go)
            flags_next[arm_idx] = 1'b0;
        if (scan_hit)
            flags_next[cnt_reg] = 1'b1;

        exp_we    = arm_go || scan_hit;
        exp_addr  = arm_go ? arm_idx : cnt_reg;
        exp_wdata = arm_go ? time_reg + TIME_BITS'(period) : '1;

        if (ctrl.accept)
            cnt_next = '0;
        else if (ctrl.scan_step)
            cnt_next = cnt_reg + CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    // flag of the addressed channel, zero beyond the channel count
    assign sel_bit = ({1'b0, idx_reg} < CH_LIMIT) ? flags_reg[idx_reg[CNT_W-1:0]] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            flags_reg <= '0;
            cnt_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
                expiry_reg[c] <= '1;
        end
        else
        begin
            time_reg  <= time_next;
            flags_reg <= flags_next;
            cnt_reg   <= cnt_next;
            if (exp_we)
                expiry_reg[exp_addr] <= exp_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            idx_reg <= timer_index;
            rej_reg <= (cmd_t'(cmd) == CMD_ARM) && !in_range;
        end
        if (ctrl.load_out)
        begin
            out_time_reg   <= 32'(time_reg);
            out_events_reg <= 8'(flags_reg);
            out_sel_reg    <= sel_bit;
            out_rej_reg    <= rej_reg;
        end
    end

    assign current_time   = out_time_reg;
    assign event_bits     = out_events_reg;
    assign selected_event = out_sel_reg;
    assign rejected       = out_rej_reg;

endmodule
`default_nettype wire

@@ sv/soft_timer_bank_unit.sv @@
`default_nettype none
// tick, arm and unused commands go from acceptance through the result
//   state into the output register; a scan first walks the scan state, one channel
//   compared per cycle; one item at a time, the next accepted only once the result
//   is loaded into the output register; a waiting result holds off the next load
// reset: asynchronous active low; time and event flags clear, every expiry goes to
//   all ones (disabled), no result pending
// ----------------------------------------------------------------------------
// soft_timer_bank_unit
// bank of one-shot timeout channels driven by a wrapping tick counter
// ----------------------------------------------------------------------------
module soft_timer_bank_unit #(
    parameter int CHANNELS  = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  timer_index,
    input  wire logic [31:0] period,
    // result item channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      current_time,
    output logic [7:0]       event_bits,
    output logic             selected_event,
    output logic             rejected
);
    import stb_pkg::*;

    // command and status between the sequencer and the datapath
    stb_ctrl_t   ctrl;
    stb_status_t status;

    // sequencer: takes one item at a time, walks the scan, hands the result over
    // the output register so the next item can start while a result waits
    stb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    // datapath: tick and arm update state on the accept edge, the scan
    // compares one expiry per cycle against the time (strict unsigned
    // greater), sets the sticky flag and disables the channel on a hit
    stb_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cmd            (cmd),
        .timer_index    (timer_index),
        .period         (period),
        .status         (status),
        .current_time   (current_time),
        .event_bits     (event_bits),
        .selected_event (selected_event),
        .rejected       (rejected)
    );

endmodule
`default_nettype wire

@@ sv/stb_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stb_checker
// port-level checks on the timer bank, bound to the top level
// ----------------------------------------------------------------------------
module stb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] current_time,
    input wire logic        selected_event,
    input wire logic        rejected
);

    // one item in flight: the input is held off right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous item still in work");

    // a rejected arm names no channel, so no flag can be reported
    a_reject_no_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> !selected_event)
        else $error("rejected arm reported a selected event");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its time
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(current_time))
        else $error("stalled result changed");

endmodule

bind soft_timer_bank_unit stb_checker u_stb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .current_time   (current_time),
    .selected_event (selected_event),
    .rejected       (rejected)
);
`default_nettype wire

@@ test/timer_bank_check_pkg.sv @@
// ----------------------------------------------------------------------------
// timer_bank_check_pkg
// shadow model of the timeout channel bank and the queue of predicted results
// ----------------------------------------------------------------------------
package timer_bank_check_pkg;

    import stb_pkg::*;

    localparam int NUM_CHANNELS = 8;

    typedef struct packed {
        logic [31:0] current_time;
        logic [7:0]  event_bits;
        logic        selected_event;
        logic        rejected;
    } timer_result_t;

    class timer_bank_scoreboard;

        logic [31:0]   sys_time;
        logic [31:0]   expiry [NUM_CHANNELS];
        logic [7:0]    flags;
        timer_result_t predicted_q [$];
        int            errors;

        function new();
            sys_time = '0;
            flags    = '0;
            errors   = 0;
            foreach (expiry[c])
                expiry[c] = '1;
        endfunction

        // advance the shadow state by one accepted item, queue its result
        function void note_item(cmd_t c, logic [3:0] idx, logic [31:0] per);
            timer_result_t r;
            r = '0;
            case (c)
                CMD_TICK: sys_time = sys_time + 32'd1;
                CMD_ARM:
                begin
                    if (idx >= NUM_CHANNELS)
                        r.rejected = 1'b1;
                    else
                    begin
                        flags[idx]  = 1'b0;
                        expiry[idx] = sys_time + per;
                    end
                end
                CMD_SCAN:
                begin
                    for (int ch = 0; ch < NUM_CHANNELS; ch++)
                    begin
                        if (sys_time > expiry[ch])
                        begin
                            flags[ch]  = 1'b1;
                            expiry[ch] = '1;
                        end
                    end
                end
                default: ;
            endcase
            if (idx < NUM_CHANNELS)
                r.selected_event = flags[idx];
            r.current_time = sys_time;
            r.event_bits   = flags;
            predicted_q.push_back(r);
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t exp_r;
            if (predicted_q.size() == 0)
            begin
                $error("result item with nothing predicted: time %0h", got.current_time);
                errors++;
                return;
            end
            exp_r = predicted_q.pop_front();
            if (got.current_time !== exp_r.current_time)
            begin
                $error("current_time: expected %0h, got %0h",
                       exp_r.current_time, got.current_time);
                errors++;
            end
            if (got.event_bits !== exp_r.event_bits)
            begin
                $error("event_bits: expected %0h, got %0h",
                       exp_r.event_bits, got.event_bits);
                errors++;
            end
            if (got.selected_event !== exp_r.selected_event)
            begin
                $error("selected_event: expected %0b, got %0b",
                       exp_r.selected_event, got.selected_event);
                errors++;
            end
            if (got.rejected !== exp_r.rejected)
            begin
                $error("rejected: expected %0b, got %0b", exp_r.rejected, got.rejected);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

    endclass

endpackage

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives command items into the timer bank under random bursts and output
// stalls, and checks every result item against a shadow model of the bank
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;
    import timer_bank_check_pkg::*;

    localparam int RANDOM_ITEMS   = 1380;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = 2'd0;
    logic [3:0]  timer_index = 4'd0;
    logic [31:0] period = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] current_time;
    logic [7:0]  event_bits;
    logic        selected_event;
    logic        rejected;

    timer_bank_scoreboard sb = new();

    // sender burst bookkeeping and a copy of the time as the driver sees it
    int          burst_left = 0;
    logic [31:0] drv_time = '0;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          stall_hold = 0;

    int          idle_cycles = 0;

    soft_timer_bank_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .timer_index    (timer_index),
        .period         (period),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_time   (current_time),
        .event_bits     (event_bits),
        .selected_event (selected_event),
        .rejected       (rejected)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // predict on every accepted input item
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(cmd_t'(cmd), timer_index, period);
    end

    // check every accepted result item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{current_time, event_bits, selected_event, rejected});
    end

    // receiver stall: switch between free flow, random stalls and heavy stalls
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(20, 200);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("soft_timer_bank_unit: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // drive one item, with a random gap whenever a burst runs out;
    // returns at the edge where the item is accepted
    task automatic send_item(input cmd_t c, input logic [3:0] idx, input logic [31:0] per);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        cmd         <= c;
        timer_index <= idx;
        period      <= per;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_TICK)
            drv_time = drv_time + 32'd1;
    endtask

    // random but mostly meaningful traffic: short timeouts, wrapped expiries,
    // expiries landing on the disabled value, out of range channels and noise
    task automatic send_random_item();
        int          pick;
        cmd_t        c;
        logic [3:0]  idx;
        logic [31:0] per;
        pick = $urandom_range(0, 99);
        idx  = 4'($urandom_range(0, 15));
        per  = $urandom;
        if (pick < 38)
            c = CMD_TICK;
        else if (pick < 70)
        begin
            c = CMD_ARM;
            if ($urandom_range(0, 9) != 0)
                idx = 4'($urandom_range(0, NUM_CHANNELS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                per = 32'($urandom_range(0, 24));
            else if (pick < 75)
                per = 32'hFFFF_FFFF - 32'($urandom_range(0, 30));
            else if (pick < 85)
                per = ~drv_time;
        end
        else if (pick < 95)
            c = CMD_SCAN;
        else
            c = CMD_NONE;
        send_item(c, idx, per);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scan right after reset: every channel disabled, nothing fires
        send_item(CMD_SCAN, 4'd0, 32'd0);
        // zero period at time zero only fires once time has moved on
        send_item(CMD_ARM, 4'd0, 32'd0);
        send_item(CMD_SCAN, 4'd0, 32'd0);
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_SCAN, 4'd0, 32'd0);
        // arms beyond the channel count are ignored and flagged
        send_item(CMD_ARM, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_ARM, 4'd8, 32'd5);
        // out of range selection on other commands reports no flag
        send_item(CMD_TICK, 4'd12, 32'h5555_5555);
        // unused command leaves everything alone
        send_item(CMD_NONE, 4'd0, 32'hAAAA_AAAA);
        // expiry wrapping past zero fires at once, as the wrapped value lies below the time
        send_item(CMD_ARM, 4'd7, 32'hFFFF_FFFF);
        send_item(CMD_SCAN, 4'd7, 32'd0);
        // expiry landing on all ones never fires
        send_item(CMD_ARM, 4'd1, ~drv_time);
        send_item(CMD_TICK, 4'd1, 32'd0);
        send_item(CMD_TICK, 4'd1, 32'd0);
        send_item(CMD_SCAN, 4'd1, 32'd0);
        // re-arming a fired channel clears its sticky flag
        send_item(CMD_ARM, 4'd0, 32'd1);
        send_item(CMD_ARM, 4'd2, 32'd0);
        send_item(CMD_ARM, 4'd3, 32'h8000_0000);
        send_item(CMD_ARM, 4'd4, 32'h7FFF_FFFF);
        send_item(CMD_ARM, 4'd5, 32'h5555_5555);
        send_item(CMD_ARM, 4'd6, 32'hAAAA_AAAA);
        send_item(CMD_TICK, 4'd2, 32'd0);
        send_item(CMD_TICK, 4'd2, 32'd0);
        send_item(CMD_SCAN, 4'd2, 32'd0);
        send_item(CMD_SCAN, 4'd0, 32'd0);

        repeat (RANDOM_ITEMS)
            send_random_item();

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        // catch any stray result after the last predicted one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("soft_timer_bank_unit: match");
        else
            $display("soft_timer_bank_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/stb_pkg.sv
sv/stb_ctrl.sv
sv/stb_datapath.sv
sv/soft_timer_bank_unit.sv
sv/stb_checker.sv
test/timer_bank_check_pkg.sv
test/tb.sv
